FILE: design/lpfb_pkg.sv
// Shared types, constants and lookup tables for the LED panel frame buffer.
// No dependencies; every other design file imports this package.
package lpfb_pkg;

  localparam int unsigned ROWS            = 16;
  localparam int unsigned BUFFER_BYTES    = 64;
  localparam int unsigned GROUPS          = 4;
  localparam int unsigned BYTES_PER_GROUP = 4;
  localparam int unsigned COLUMN_STRIDE   = 4;
  localparam int unsigned GLYPH_COUNT     = 10;
  localparam int unsigned GLYPH_BYTES     = GROUPS * BYTES_PER_GROUP;
  localparam int unsigned ADDR_W          = $clog2(BUFFER_BYTES);

  localparam logic [1:0] MODE_SET_PIXEL   = 2'd0;
  localparam logic [1:0] MODE_CLEAR_PIXEL = 2'd1;
  localparam logic [1:0] MODE_DIGIT       = 2'd2;
  localparam logic [1:0] MODE_CLEAR_ALL   = 2'd3;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [7:0] PIXEL_MSB = 8'h80;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] pixel_x;
    logic [3:0] pixel_y;
    logic [1:0] digit_position;
    logic [3:0] digit_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] byte_index;
    logic [7:0]        byte_value;
    logic              last;
  } out_item_t;

  // Request bundle from the sequencer to the store.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              clr_all;
  } mem_req_t;

  // First buffer byte of each panel row; rows are interleaved by the scan order.
  localparam logic [ADDR_W-1:0] SCAN_ROW [0:ROWS-1] = '{
    6'd51, 6'd3, 6'd19, 6'd35,
    6'd50, 6'd2, 6'd18, 6'd34,
    6'd49, 6'd1, 6'd17, 6'd33,
    6'd48, 6'd0, 6'd16, 6'd32
  };

  localparam logic [7:0] GLYPH_ROM [0:GLYPH_COUNT*GLYPH_BYTES-1] = '{
    8'h7F,8'h63,8'h63,8'h7F, 8'h7F,8'h63,8'h63,8'h7F,
    8'h00,8'h63,8'h63,8'h63, 8'h63,8'h63,8'h63,8'h00,
    8'h03,8'h03,8'h03,8'h03, 8'h03,8'h03,8'h03,8'h03,
    8'h00,8'h03,8'h03,8'h03, 8'h03,8'h03,8'h03,8'h00,
    8'h7F,8'h60,8'h03,8'h7F, 8'h7F,8'h60,8'h03,8'h7F,
    8'h00,8'h60,8'h7F,8'h03, 8'h60,8'h7F,8'h03,8'h00,
    8'h7F,8'h03,8'h03,8'h7F, 8'h7F,8'h03,8'h03,8'h7F,
    8'h00,8'h03,8'h7F,8'h03, 8'h03,8'h7F,8'h03,8'h00,
    8'h03,8'h03,8'h63,8'h63, 8'h03,8'h03,8'h63,8'h63,
    8'h00,8'h03,8'h7F,8'h63, 8'h03,8'h7F,8'h63,8'h00,
    8'h7F,8'h03,8'h60,8'h7F, 8'h7F,8'h03,8'h60,8'h7F,
    8'h00,8'h03,8'h7F,8'h60, 8'h03,8'h7F,8'h60,8'h00,
    8'h7F,8'h63,8'h60,8'h7F, 8'h7F,8'h63,8'h60,8'h7F,
    8'h00,8'h63,8'h7F,8'h60, 8'h63,8'h7F,8'h60,8'h00,
    8'h03,8'h03,8'h03,8'h7F, 8'h03,8'h03,8'h03,8'h7F,
    8'h00,8'h03,8'h03,8'h03, 8'h03,8'h03,8'h03,8'h00,
    8'h7F,8'h63,8'h63,8'h7F, 8'h7F,8'h63,8'h63,8'h7F,
    8'h00,8'h63,8'h7F,8'h63, 8'h63,8'h7F,8'h63,8'h00,
    8'h7F,8'h03,8'h63,8'h7F, 8'h7F,8'h03,8'h63,8'h7F,
    8'h00,8'h03,8'h7F,8'h63, 8'h03,8'h7F,8'h63,8'h00
  };

  // Glyph byte n of digit dig; digits above nine read as blank.
  function automatic logic [7:0] glyph_byte(input logic [3:0] dig, input logic [3:0] n);
    logic [7:0] val;
    val = 8'h00;
    if (dig < 4'(GLYPH_COUNT)) begin
      val = GLYPH_ROM[{dig, n}];
    end
    return val;
  endfunction

endpackage

FILE: design/lpfb_store.sv
// Frame store: 64 x 8 synchronous memory with registered read.
// Per-entry valid flags make unwritten or cleared entries read as zero.
// Depends on lpfb_pkg.
module lpfb_store
  import lpfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0]              mem [0:BUFFER_BYTES-1];
  logic [BUFFER_BYTES-1:0] valid_r;
  logic [7:0]              rd_data_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.clr_all) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : 8'h00;

endmodule

FILE: design/led_panel_frame_buffer.sv
// LED panel frame buffer: pixel set/clear with read-modify-write, glyph writes, clear.
// A pixel or clear item is taken in idle and its result is registered from ST_PIXEL or ST_CLEAR; a digit
// registers one byte per cycle from ST_DIGIT, each held by out_stall while the link is open.
// A new item is taken only once the sequencer is back in idle, after the sixteen byte writes of a
// digit; a stalled result holds the sequencer.
// Reset (synchronous, rst_n low) empties the store through its valid flags at once,
// closes the link and drops any pending result; there is no clearing pass.
module led_panel_frame_buffer
  import lpfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  // Sequencer states. An item is only taken in idle; an item can be taken while a result
  // waits, but the sequencer holds until the result register is free for its own result.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PIXEL = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic              link_open_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // Captured item context.
  logic [ADDR_W-1:0] pix_idx_r, pix_idx_nxt;
  logic [7:0]        pix_mask_r, pix_mask_nxt;
  logic              pix_set_r, pix_set_nxt;
  logic [1:0]        dig_pos_r, dig_pos_nxt;
  logic [3:0]        dig_val_r, dig_val_nxt;
  logic [3:0]        dig_cnt_r, dig_cnt_nxt;

  mem_req_t          req;
  logic [7:0]        rd_data;
  logic              in_accept;
  logic              out_free;
  logic [ADDR_W-1:0] in_pix_idx;
  logic [7:0]        pix_new;
  logic [ADDR_W-1:0] dig_idx;
  logic [7:0]        dig_byte;

  lpfb_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Byte index of a pixel: scan row base plus four bytes per eight columns.
  assign in_pix_idx = SCAN_ROW[in_item.pixel_y] + {2'b00, in_item.pixel_x[4:3], 2'b00};

  assign pix_new = pix_set_r ? (rd_data | pix_mask_r) : (rd_data & ~pix_mask_r);

  // Digit byte counter is {group, byte within group}; the slot picks the column.
  assign dig_idx  = {dig_cnt_r[3:2], dig_pos_r, dig_cnt_r[1:0]};
  assign dig_byte = glyph_byte(dig_val_r, dig_cnt_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    pix_idx_nxt   = pix_idx_r;
    pix_mask_nxt  = pix_mask_r;
    pix_set_nxt   = pix_set_r;
    dig_pos_nxt   = dig_pos_r;
    dig_val_nxt   = dig_val_r;
    dig_cnt_nxt   = dig_cnt_r;
    req           = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          pix_idx_nxt  = in_pix_idx;
          pix_mask_nxt = PIXEL_MSB >> in_item.pixel_x[2:0];
          pix_set_nxt  = (in_item.mode == MODE_SET_PIXEL);
          dig_pos_nxt  = in_item.digit_position;
          dig_val_nxt  = in_item.digit_value;
          dig_cnt_nxt  = '0;
          case (in_item.mode)
            MODE_SET_PIXEL, MODE_CLEAR_PIXEL: begin
              // Fetch the byte now; it is modified once the read returns.
              req.rd_en   = 1'b1;
              req.rd_addr = in_pix_idx;
              state_nxt   = ST_PIXEL;
            end
            MODE_DIGIT: begin
              state_nxt = ST_DIGIT;
            end
            MODE_CLEAR_ALL: begin
              req.clr_all = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_PIXEL: begin
        // Read data stays put while we wait for the result register.
        if (out_free) begin
          req.wr_en     = 1'b1;
          req.wr_addr   = pix_idx_r;
          req.wr_data   = pix_new;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_PIXEL, byte_index: pix_idx_r,
                            byte_value: pix_new, last: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end

      ST_DIGIT: begin
        // With the link closed the glyph is written at one byte per cycle
        // and nothing is reported.
        if (!link_open_r || out_free) begin
          req.wr_en   = 1'b1;
          req.wr_addr = dig_idx;
          req.wr_data = dig_byte;
          if (link_open_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{kind: KIND_UPDATE, byte_index: dig_idx,
                              byte_value: dig_byte, last: (dig_cnt_r == 4'hF)};
          end
          dig_cnt_nxt = dig_cnt_r + 4'd1;
          if (dig_cnt_r == 4'hF) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_CLEAR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_DONE, byte_index: '0,
                            byte_value: 8'h00, last: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      link_open_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        link_open_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    pix_idx_r  <= pix_idx_nxt;
    pix_mask_r <= pix_mask_nxt;
    pix_set_r  <= pix_set_nxt;
    dig_pos_r  <= dig_pos_nxt;
    dig_val_r  <= dig_val_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: sim/led_panel_frame_buffer_check.sv
// Checker for the LED panel frame buffer: watches both channels and the link register,
// keeps its own copy of the 64-byte image and compares every result with its prediction.
// Depends on lpfb_pkg for the item types and the mode and kind codes.
module led_panel_frame_buffer_check
  import lpfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int unsigned pending_count,
  output int unsigned fail_count
);

  // First byte of each panel row, in scan order.
  localparam logic [5:0] ROW_BASE [0:15] = '{
    6'd51, 6'd3, 6'd19, 6'd35,
    6'd50, 6'd2, 6'd18, 6'd34,
    6'd49, 6'd1, 6'd17, 6'd33,
    6'd48, 6'd0, 6'd16, 6'd32
  };

  // Sixteen bytes per digit, four groups of four.
  localparam logic [7:0] DIGIT_FONT [0:159] = '{
    8'h7F,8'h63,8'h63,8'h7F, 8'h7F,8'h63,8'h63,8'h7F,
    8'h00,8'h63,8'h63,8'h63, 8'h63,8'h63,8'h63,8'h00,
    8'h03,8'h03,8'h03,8'h03, 8'h03,8'h03,8'h03,8'h03,
    8'h00,8'h03,8'h03,8'h03, 8'h03,8'h03,8'h03,8'h00,
    8'h7F,8'h60,8'h03,8'h7F, 8'h7F,8'h60,8'h03,8'h7F,
    8'h00,8'h60,8'h7F,8'h03, 8'h60,8'h7F,8'h03,8'h00,
    8'h7F,8'h03,8'h03,8'h7F, 8'h7F,8'h03,8'h03,8'h7F,
    8'h00,8'h03,8'h7F,8'h03, 8'h03,8'h7F,8'h03,8'h00,
    8'h03,8'h03,8'h63,8'h63, 8'h03,8'h03,8'h63,8'h63,
    8'h00,8'h03,8'h7F,8'h63, 8'h03,8'h7F,8'h63,8'h00,
    8'h7F,8'h03,8'h60,8'h7F, 8'h7F,8'h03,8'h60,8'h7F,
    8'h00,8'h03,8'h7F,8'h60, 8'h03,8'h7F,8'h60,8'h00,
    8'h7F,8'h63,8'h60,8'h7F, 8'h7F,8'h63,8'h60,8'h7F,
    8'h00,8'h63,8'h7F,8'h60, 8'h63,8'h7F,8'h60,8'h00,
    8'h03,8'h03,8'h03,8'h7F, 8'h03,8'h03,8'h03,8'h7F,
    8'h00,8'h03,8'h03,8'h03, 8'h03,8'h03,8'h03,8'h00,
    8'h7F,8'h63,8'h63,8'h7F, 8'h7F,8'h63,8'h63,8'h7F,
    8'h00,8'h63,8'h7F,8'h63, 8'h63,8'h7F,8'h63,8'h00,
    8'h7F,8'h03,8'h63,8'h7F, 8'h7F,8'h03,8'h63,8'h7F,
    8'h00,8'h03,8'h7F,8'h63, 8'h03,8'h7F,8'h63,8'h00
  };

  logic [7:0]  panel_bytes [0:63];
  logic        link_copy;
  out_item_t   due_reports [$];
  int unsigned errs = 0;

  // Applies one command to the image copy and queues the reports it causes.
  task automatic apply_command(input in_item_t cmd);
    logic [5:0] idx;
    logic [7:0] mask;
    logic [7:0] val;
    out_item_t  rep;
    case (cmd.mode)
      MODE_SET_PIXEL, MODE_CLEAR_PIXEL: begin
        idx  = ROW_BASE[cmd.pixel_y] + {2'b00, cmd.pixel_x[4:3], 2'b00};
        mask = 8'h80 >> cmd.pixel_x[2:0];
        if (cmd.mode == MODE_SET_PIXEL) begin
          panel_bytes[idx] = panel_bytes[idx] | mask;
        end else begin
          panel_bytes[idx] = panel_bytes[idx] & ~mask;
        end
        rep.kind       = KIND_PIXEL;
        rep.byte_index = idx;
        rep.byte_value = panel_bytes[idx];
        rep.last       = 1'b1;
        due_reports.push_back(rep);
      end
      MODE_DIGIT: begin
        for (int g = 0; g < 4; g++) begin
          for (int b = 0; b < 4; b++) begin
            idx = {2'(g), cmd.digit_position, 2'(b)};
            val = (cmd.digit_value < 4'd10) ?
                  DIGIT_FONT[cmd.digit_value * 16 + g * 4 + b] : 8'h00;
            panel_bytes[idx] = val;
            if (link_copy) begin
              rep.kind       = KIND_UPDATE;
              rep.byte_index = idx;
              rep.byte_value = val;
              rep.last       = (g == 3 && b == 3);
              due_reports.push_back(rep);
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < 64; i++) panel_bytes[i] = 8'h00;
        rep.kind       = KIND_DONE;
        rep.byte_index = '0;
        rep.byte_value = 8'h00;
        rep.last       = 1'b1;
        due_reports.push_back(rep);
      end
    endcase
  endtask

  task automatic compare_report(input out_item_t got, input out_item_t want);
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      errs++;
    end
    if (got.byte_index !== want.byte_index) begin
      $error("byte_index: expected %0d, actual %0d", want.byte_index, got.byte_index);
      errs++;
    end
    if (got.byte_value !== want.byte_value) begin
      $error("byte_value: expected 0x%02h, actual 0x%02h",
             want.byte_value, got.byte_value);
      errs++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 64; i++) panel_bytes[i] = 8'h00;
      link_copy = 1'b0;
      due_reports.delete();
    end else begin
      // A result never belongs to an item taken at the same edge, so results go first.
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          $error("result with nothing expected: kind %0d, byte_index %0d, %s",
                 out_item.kind, out_item.byte_index,
                 $sformatf("byte_value 0x%02h, last %0d",
                           out_item.byte_value, out_item.last));
          errs++;
        end else begin
          compare_report(out_item, due_reports.pop_front());
        end
      end
      if (cfg_wr_en) begin
        link_copy = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        apply_command(in_item);
      end
    end
    pending_count <= due_reports.size();
    fail_count    <= errs;
  end

endmodule

FILE: sim/led_panel_frame_buffer_tb.sv
// Testbench top for the LED panel frame buffer: clock, reset, directed and random items,
// random stalls on both channels, link register writes and the final verdict.
// Depends on lpfb_pkg, led_panel_frame_buffer and led_panel_frame_buffer_check.
module led_panel_frame_buffer_tb
  import lpfb_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  int unsigned pending_count;
  int unsigned fail_count;

  // When set, both sides run without idle cycles.
  logic steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_panel_frame_buffer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  led_panel_frame_buffer_check frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .pending_count (pending_count),
    .fail_count    (fail_count)
  );

  // Builds one item from all of its fields, including the ones the mode ignores.
  function automatic in_item_t cmd(input logic [1:0] m, input logic [4:0] x,
                                   input logic [3:0] y, input logic [1:0] p,
                                   input logic [3:0] d);
    in_item_t c;
    c.mode           = m;
    c.pixel_x        = x;
    c.pixel_y        = y;
    c.digit_position = p;
    c.digit_value    = d;
    return c;
  endfunction

  // Random item: pixel operations dominate, digits are mostly legal, and clears are
  // rare enough that the image builds up between them. Unused fields stay random.
  function automatic in_item_t random_cmd();
    in_item_t c;
    int unsigned pick;
    c    = in_item_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c.mode = MODE_SET_PIXEL;
    end else if (pick < 60) begin
      c.mode = MODE_CLEAR_PIXEL;
    end else if (pick < 90) begin
      c.mode = MODE_DIGIT;
      if ($urandom_range(0, 7) != 0) c.digit_value = 4'($urandom_range(0, 9));
    end else begin
      c.mode = MODE_CLEAR_ALL;
    end
    return c;
  endfunction

  // Offers one item after a random gap and returns at the edge that takes it.
  // The valid line is left high, so a following item with no gap goes straight on.
  task automatic send(input in_item_t c);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Holds the input off until every expected result has come, then waits well past
  // any digit write that reports nothing (sixteen bytes at one a cycle) before
  // anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // The link register is only written while the block is idle.
  task automatic set_link(input logic open);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= open;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Result side: before each result it stalls for a random number of cycles, then
  // takes the next result as soon as one is offered.
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin
    in_valid    <= 1'b0;
    in_item     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    rst_n       <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Link closed after reset: pixels at both corners of the panel and at the first
    // byte, a digit write that reports nothing, then a pixel on top of that glyph.
    send(cmd(MODE_SET_PIXEL,   5'd0,  4'd0,  2'd3, 4'd15));
    send(cmd(MODE_SET_PIXEL,   5'd31, 4'd15, 2'd0, 4'd0));
    send(cmd(MODE_SET_PIXEL,   5'd7,  4'd13, 2'd1, 4'd6));
    send(cmd(MODE_CLEAR_PIXEL, 5'd31, 4'd15, 2'd2, 4'd9));
    send(cmd(MODE_DIGIT,       5'd31, 4'd15, 2'd3, 4'd8));
    send(cmd(MODE_SET_PIXEL,   5'd24, 4'd0,  2'd0, 4'd0));
    send(cmd(MODE_SET_PIXEL,   5'd25, 4'd12, 2'd2, 4'd3));
    send(cmd(MODE_CLEAR_PIXEL, 5'd0,  4'd0,  2'd1, 4'd1));
    // A digit above nine blanks its slot.
    send(cmd(MODE_DIGIT,       5'd0,  4'd0,  2'd0, 4'd15));
    send(cmd(MODE_CLEAR_ALL,   5'd31, 4'd15, 2'd3, 4'd15));

    // Link open: digits report all sixteen bytes, in every slot, blank ones included.
    set_link(1'b1);
    send(cmd(MODE_DIGIT,       5'd0,  4'd0,  2'd0, 4'd0));
    send(cmd(MODE_DIGIT,       5'd17, 4'd9,  2'd1, 4'd9));
    send(cmd(MODE_DIGIT,       5'd3,  4'd2,  2'd2, 4'd10));
    send(cmd(MODE_DIGIT,       5'd31, 4'd15, 2'd3, 4'd15));
    send(cmd(MODE_DIGIT,       5'd8,  4'd4,  2'd3, 4'd4));
    send(cmd(MODE_SET_PIXEL,   5'd8,  4'd1,  2'd0, 4'd2));
    send(cmd(MODE_SET_PIXEL,   5'd15, 4'd1,  2'd1, 4'd7));
    send(cmd(MODE_CLEAR_PIXEL, 5'd8,  4'd1,  2'd2, 4'd5));
    send(cmd(MODE_CLEAR_PIXEL, 5'd0,  4'd3,  2'd3, 4'd11));
    send(cmd(MODE_CLEAR_ALL,   5'd0,  4'd0,  2'd0, 4'd0));
    send(cmd(MODE_SET_PIXEL,   5'd31, 4'd0,  2'd1, 4'd12));

    // Random phases alternate the link setting. One phase runs with no idling on
    // either side, and one pauses midway until every result has come back.
    for (int phase = 0; phase < 6; phase++) begin
      set_link(phase[0]);
      steady = (phase == 3);
      for (int n = 0; n < 32; n++) begin
        if (phase == 1 && n == 16) drain();
        send(random_cmd());
      end
      steady = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #6000000;
    $display("Verification failed");
    $finish;
  end

endmodule
